>>> src/brl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_pkg
// Shared constants, types and helpers of the line rasterizer.
// ----------------------------------------------------------------------------
package brl_pkg;

  localparam int TILE_SIZE = 64;
  localparam int COORD_W   = 6;
  localparam int ERR_W     = 8;

  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(TILE_SIZE - 1);
  localparam logic [COORD_W-1:0] STEP_MAX  = COORD_W'(TILE_SIZE - 1);

  typedef logic [COORD_W-1:0] coord_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch a new line request
    logic step;       // advance the walk by one major step
    logic emit;       // load the output word
    logic emit_last;  // output word is the end point
  } brl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_end;
  } brl_stat_t;

  function automatic coord_t clamp_coord(input coord_t v);
    coord_t c;
    c = v;
    if (c > COORD_MAX) begin
      c = COORD_MAX;
    end
    return c;
  endfunction

endpackage

>>> src/brl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_datapath
// Position, error and delta registers of the walk, plus the output word.
// ----------------------------------------------------------------------------
module brl_datapath (
  input  logic                 clk,
  input  brl_pkg::brl_cmd_t    cmd,
  output brl_pkg::brl_stat_t   stat,
  input  brl_pkg::coord_t      in_x_start,
  input  brl_pkg::coord_t      in_y_start,
  input  brl_pkg::coord_t      in_x_end,
  input  brl_pkg::coord_t      in_y_end,
  output brl_pkg::coord_t      out_pixel_x,
  output brl_pkg::coord_t      out_pixel_y,
  output logic                 out_last_pixel
);

  brl_pkg::coord_t cur_x_r, cur_y_r, end_x_r, end_y_r;
  brl_pkg::coord_t dmaj_r, dmin_r, cnt_r;
  logic signed [brl_pkg::ERR_W-1:0] err_r;
  logic x_major_r, x_down_r, y_down_r;
  brl_pkg::coord_t pix_x_r, pix_y_r;
  logic last_r;

  brl_pkg::coord_t xs, ys, xe, ye, adx, ady;
  logic [brl_pkg::COORD_W:0] dx, dy;
  logic x_major_nxt;
  logic signed [brl_pkg::ERR_W-1:0] err_sub, err_nxt;
  brl_pkg::coord_t cur_x_nxt, cur_y_nxt;
  brl_pkg::coord_t x_adv, y_adv;

  always_comb begin
    xs  = brl_pkg::clamp_coord(in_x_start);
    ys  = brl_pkg::clamp_coord(in_y_start);
    xe  = brl_pkg::clamp_coord(in_x_end);
    ye  = brl_pkg::clamp_coord(in_y_end);
    dx  = {1'b0, xe} - {1'b0, xs};
    dy  = {1'b0, ye} - {1'b0, ys};
    adx = dx[brl_pkg::COORD_W] ? brl_pkg::COORD_W'(-dx) : dx[brl_pkg::COORD_W-1:0];
    ady = dy[brl_pkg::COORD_W] ? brl_pkg::COORD_W'(-dy) : dy[brl_pkg::COORD_W-1:0];
    x_major_nxt = adx > ady;
  end

  always_comb begin
    x_adv   = x_down_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
    y_adv   = y_down_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    err_sub = err_r - $signed({2'b00, dmin_r});
    err_nxt = err_sub;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    // minor axis steps when the error goes negative
    if (err_sub < 0) begin
      err_nxt = err_sub + $signed({2'b00, dmaj_r});
    end
    if (x_major_r) begin
      cur_x_nxt = x_adv;
      if (err_sub < 0) cur_y_nxt = y_adv;
    end else begin
      cur_y_nxt = y_adv;
      if (err_sub < 0) cur_x_nxt = x_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x_r   <= xs;
      cur_y_r   <= ys;
      end_x_r   <= xe;
      end_y_r   <= ye;
      x_major_r <= x_major_nxt;
      x_down_r  <= dx[brl_pkg::COORD_W] || (dx == '0);
      y_down_r  <= dy[brl_pkg::COORD_W] || (dy == '0);
      dmaj_r    <= x_major_nxt ? adx : ady;
      dmin_r    <= x_major_nxt ? ady : adx;
      err_r     <= $signed({2'b00, (x_major_nxt ? adx : ady) >> 1});
      cnt_r     <= '0;
    end else if (cmd.step) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      err_r   <= err_nxt;
      cnt_r   <= cnt_r + 1'b1;
    end
    if (cmd.emit) begin
      pix_x_r <= cmd.emit_last ? end_x_r : cur_x_r;
      pix_y_r <= cmd.emit_last ? end_y_r : cur_y_r;
      last_r  <= cmd.emit_last;
    end
  end

  assign stat.at_end = (x_major_r ? (cur_x_r == end_x_r) : (cur_y_r == end_y_r))
                       || (cnt_r == brl_pkg::STEP_MAX);

  assign out_pixel_x    = pix_x_r;
  assign out_pixel_y    = pix_y_r;
  assign out_last_pixel = last_r;

endmodule

>>> src/brl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_ctrl
// Sequencer: takes a request, walks it one pixel a cycle while the output is free, owns out_valid.
// ----------------------------------------------------------------------------
module brl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  brl_pkg::brl_stat_t  stat,
  output brl_pkg::brl_cmd_t   cmd
);

  typedef enum logic {
    IDLE,
    WALK
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall = (state_r != IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = WALK;
        end
      end
      WALK: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          if (stat.at_end) begin
            cmd.emit_last = 1'b1;
            state_nxt     = IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: state_nxt = IDLE;
    endcase
    // hold the word while stalled, drop it once taken
    out_valid_nxt = cmd.emit ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/bresenham_line_rasterizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_unit
// Bresenham line walker for one 64 by 64 tile.
// ----------------------------------------------------------------------------
// A request carries start and end points; the unit emits every pixel from
// start to end, one word per cycle while out_stall is low, and flags the end
// point with out_last_pixel. A line of major delta D gives D+1 words, the
// unit latching the request and then emitting each pixel from the single
// error/position update loop; the next request is taken once the end point
// has entered the output register. The output register lets the walk
// finish while the last word waits to be taken.
module bresenham_line_rasterizer_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  brl_pkg::coord_t in_x_start,
  input  brl_pkg::coord_t in_y_start,
  input  brl_pkg::coord_t in_x_end,
  input  brl_pkg::coord_t in_y_end,
  output logic            out_valid,
  input  logic            out_stall,
  output brl_pkg::coord_t out_pixel_x,
  output brl_pkg::coord_t out_pixel_y,
  output logic            out_last_pixel
);

  brl_pkg::brl_cmd_t  cmd;
  brl_pkg::brl_stat_t stat;

  brl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  brl_datapath u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .stat           (stat),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

endmodule
